@@ rtl/core/month_calendar_grid_top_defines.svh @@
// assertion macros shared by the calendar grid rtl
`ifndef MONTH_CALENDAR_GRID_TOP_DEFINES_SVH
`define MONTH_CALENDAR_GRID_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked on every clock outside reset
`define MCG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("calendar grid check failed");
// next-cycle implication
`define MCG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("calendar grid check failed");
`else
`define MCG_ASSERT_NOW(lbl, ante, cons)
`define MCG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/mcg_pkg.sv @@
package mcg_pkg;

    // grid shape
    localparam int GRID_ROWS  = 6;
    localparam int GRID_COLS  = 7;
    localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;

    // accepted input ranges
    localparam int YEAR_MIN  = 1800;
    localparam int YEAR_MAX  = 3000;
    localparam int MONTH_MAX = 12;
    localparam logic [3:0] MONTH_FEB = 4'd2;

    // reciprocal multipliers for constant division
    localparam logic [12:0] RECIP_100       = 13'd5243;
    localparam int          RECIP_100_SHIFT = 19;
    localparam logic [12:0] RECIP_7         = 13'd4682;
    localparam int          RECIP_7_SHIFT   = 15;

    // descriptor queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_YEAR_RANGE  = 2'd1,
        ST_MONTH_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        t_status    status;
        logic [2:0] first;
        logic [4:0] ndays;
    } t_grid_desc;

    // days in a common year
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd2:                     len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

    // (m * 3057 - 3007) / 100, day offset of the first of the month
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] off;
        unique case (m)
            4'd2:    off = 9'd31;
            4'd3:    off = 9'd61;
            4'd4:    off = 9'd92;
            4'd5:    off = 9'd122;
            4'd6:    off = 9'd153;
            4'd7:    off = 9'd183;
            4'd8:    off = 9'd214;
            4'd9:    off = 9'd245;
            4'd10:   off = 9'd275;
            4'd11:   off = 9'd306;
            4'd12:   off = 9'd336;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

@@ rtl/core/mcg_ifs.sv @@
// request channel: one month and year per item
interface mcg_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  month;
    logic [11:0] year;

    modport source (output valid, output month, output year, input ready);
    modport sink   (input valid, input month, input year, output ready);
endinterface

// result channel: one grid cell per item
interface mcg_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] week_row;
    logic [2:0] weekday_col;
    logic [4:0] day_number;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output week_row, output weekday_col,
                    output day_number, output status, output last, input ready);
    modport sink   (input valid, input week_row, input weekday_col,
                    input day_number, input status, input last, output ready);
endinterface

@@ rtl/core/mcg_front.sv @@
module mcg_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mcg_in_if.sink              i_req,
    input  logic                i_q_full,
    output logic                o_push,
    output mcg_pkg::t_grid_desc o_push_desc
);

    logic               en;
    logic               acc;
    logic               year_bad;
    logic               month_bad;
    mcg_pkg::t_status   status_in;
    logic [11:0]        py_in;
    logic [24:0]        prod100;

    logic               r_v1;
    mcg_pkg::t_status   r_status1;
    logic [3:0]         r_month1;
    logic [11:0]        r_py1;
    logic [5:0]         r_q100_1;

    logic [11:0]        q_x100;
    logic [6:0]         rem100;
    logic               leap;
    logic [1:0]         adj;
    logic [4:0]         ndays2;
    logic [12:0]        sum2;

    logic               r_v2;
    mcg_pkg::t_status   r_status2;
    logic [4:0]         r_ndays2;
    logic [12:0]        r_sum2;

    logic [25:0]        prod7;

    logic               r_v3;
    mcg_pkg::t_status   r_status3;
    logic [4:0]         r_ndays3;
    logic [12:0]        r_sum3;
    logic [10:0]        r_q7_3;
    logic [12:0]        q_x7;

    // whole pipe holds while the last stage cannot push
    assign en          = !r_v3 || !i_q_full;
    assign i_req.ready = en;
    assign acc         = i_req.valid && en;

    // classify and start the year / 100 product
    always_comb begin
        year_bad  = (i_req.year < 12'(mcg_pkg::YEAR_MIN)) ||
                    (i_req.year > 12'(mcg_pkg::YEAR_MAX));
        month_bad = (i_req.month == 4'd0) || (i_req.month > 4'(mcg_pkg::MONTH_MAX));
        if (year_bad) begin
            status_in = mcg_pkg::ST_YEAR_RANGE;
        end else if (month_bad) begin
            status_in = mcg_pkg::ST_MONTH_RANGE;
        end else begin
            status_in = mcg_pkg::ST_OK;
        end
        py_in   = i_req.year - 12'd1;
        prod100 = 25'(py_in) * 25'(mcg_pkg::RECIP_100);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_status1 <= status_in;
            r_month1  <= i_req.month;
            r_py1     <= py_in;
            r_q100_1  <= prod100[mcg_pkg::RECIP_100_SHIFT +: 6];
        end
    end

    // leap rule and day count mod-7 sum; y%100==0 is (y-1)%100==99
    always_comb begin
        q_x100 = 12'(r_q100_1) * 12'd100;
        rem100 = 7'(r_py1 - q_x100);
        leap   = (r_py1[1:0] == 2'b11) && ((rem100 != 7'd99) || (r_q100_1[1:0] == 2'b11));
        ndays2 = mcg_pkg::month_len(r_month1) + 5'((r_month1 == mcg_pkg::MONTH_FEB) && leap);
        if (r_month1 > mcg_pkg::MONTH_FEB) begin
            adj = leap ? 2'd1 : 2'd2;
        end else begin
            adj = 2'd0;
        end
        sum2 = 13'(mcg_pkg::month_offset(r_month1)) + 13'(r_py1) + 13'(r_py1 >> 2)
             - 13'(r_q100_1) + 13'(r_q100_1 >> 2) - 13'(adj);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_status2 <= r_status1;
            r_ndays2  <= ndays2;
            r_sum2    <= sum2;
        end
    end

    // sum / 7 by reciprocal
    assign prod7 = 26'(r_sum2) * 26'(mcg_pkg::RECIP_7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_status3 <= r_status2;
            r_ndays3  <= r_ndays2;
            r_sum3    <= r_sum2;
            r_q7_3    <= prod7[mcg_pkg::RECIP_7_SHIFT +: 11];
        end
    end

    // remainder gives the weekday of the first, monday is zero
    always_comb begin
        q_x7               = 13'(r_q7_3) * 13'd7;
        o_push             = r_v3 && !i_q_full;
        o_push_desc.status = r_status3;
        o_push_desc.ndays  = r_ndays3;
        o_push_desc.first  = 3'(r_sum3 - q_x7);
    end

endmodule

@@ rtl/core/mcg_queue.sv @@
`include "month_calendar_grid_top_defines.svh"

module mcg_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mcg_pkg::t_grid_desc i_push_desc,
    input  logic                i_pop,
    output mcg_pkg::t_grid_desc o_head,
    output logic                o_full,
    output logic                o_nonempty
);

    mcg_pkg::t_grid_desc                r_entry [mcg_pkg::QUEUE_DEPTH];
    logic [mcg_pkg::QPTR_W-1:0]         r_wr_ptr;
    logic [mcg_pkg::QPTR_W-1:0]         r_rd_ptr;
    logic [mcg_pkg::QCNT_W-1:0]         r_count;
    logic [mcg_pkg::QPTR_W-1:0]         n_wr_ptr;
    logic [mcg_pkg::QPTR_W-1:0]         n_rd_ptr;
    logic [mcg_pkg::QCNT_W-1:0]         n_count;

    assign o_full     = (r_count == mcg_pkg::QCNT_W'(mcg_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_entry[r_rd_ptr];

    // pointer and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == mcg_pkg::QPTR_W'(mcg_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == mcg_pkg::QPTR_W'(mcg_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_desc;
        end
    end

    `MCG_ASSERT_NOW(a_no_overflow, i_push, !o_full)
    `MCG_ASSERT_NOW(a_no_underflow, i_pop, o_nonempty)
    `MCG_ASSERT_NEXT(a_push_only_fills, i_push && !i_pop, r_count != '0)

endmodule

@@ rtl/core/mcg_back.sv @@
`include "month_calendar_grid_top_defines.svh"

module mcg_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mcg_pkg::t_grid_desc i_head,
    input  logic                i_nonempty,
    output logic                o_pop,
    mcg_out_if.source           o_cell
);

    logic                   r_act;
    mcg_pkg::t_grid_desc    r_desc;
    logic [5:0]             r_cell;
    logic [2:0]             r_row;
    logic [2:0]             r_col;

    logic                   r_ov;
    logic [2:0]             r_o_row;
    logic [2:0]             r_o_col;
    logic [4:0]             r_o_day;
    logic [1:0]             r_o_status;
    logic                   r_o_last;

    logic                   load;
    logic                   step;
    logic                   is_err;
    logic                   fin;
    logic [6:0]             diff;
    logic                   in_month;
    logic [4:0]             day;

    // output register takes a cell when empty or drained this cycle
    assign load   = !r_ov || o_cell.ready;
    assign step   = r_act && load;
    assign is_err = (r_desc.status != mcg_pkg::ST_OK);
    assign fin    = is_err || (r_cell == 6'(mcg_pkg::GRID_CELLS - 1));
    assign o_pop  = i_nonempty && (!r_act || (step && fin));

    // day in the current cell
    always_comb begin
        diff     = 7'(r_cell) - 7'(r_desc.first);
        in_month = (r_cell >= 6'(r_desc.first)) && (diff[5:0] < 6'(r_desc.ndays));
        day      = in_month ? 5'(diff + 7'd1) : 5'd0;
    end

    // cell walk, loads the next descriptor as the last cell goes out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (o_pop) begin
            r_act <= 1'b1;
        end else if (step && fin) begin
            r_act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_head;
            r_cell <= '0;
            r_row  <= '0;
            r_col  <= '0;
        end else if (step) begin
            r_cell <= r_cell + 6'd1;
            if (r_col == 3'(mcg_pkg::GRID_COLS - 1)) begin
                r_col <= '0;
                r_row <= r_row + 3'd1;
            end else begin
                r_col <= r_col + 3'd1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (step) begin
            r_ov <= 1'b1;
        end else if (o_cell.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_o_row    <= is_err ? 3'd0 : r_row;
            r_o_col    <= is_err ? 3'd0 : r_col;
            r_o_day    <= is_err ? 5'd0 : day;
            r_o_status <= r_desc.status;
            r_o_last   <= fin;
        end
    end

    assign o_cell.valid       = r_ov;
    assign o_cell.week_row    = r_o_row;
    assign o_cell.weekday_col = r_o_col;
    assign o_cell.day_number  = r_o_day;
    assign o_cell.status      = r_o_status;
    assign o_cell.last        = r_o_last;

    `MCG_ASSERT_NOW(a_grid_ends_at_corner,
        r_ov && r_o_last && (r_o_status == mcg_pkg::ST_OK),
        (r_o_row == 3'(mcg_pkg::GRID_ROWS - 1)) && (r_o_col == 3'(mcg_pkg::GRID_COLS - 1)))
    `MCG_ASSERT_NOW(a_error_is_single,
        r_ov && (r_o_status != mcg_pkg::ST_OK),
        r_o_last && (r_o_row == 3'd0) && (r_o_col == 3'd0) && (r_o_day == 5'd0))
    `MCG_ASSERT_NEXT(a_cell_held_on_stall, r_ov && !o_cell.ready, r_ov)

endmodule

@@ rtl/core/month_calendar_grid_top.sv @@
// Monday-first month calendar grid.
// i_req takes one item per month/year pair (valid/ready, accepted when both
// are high). o_cell gives the results: for a valid pair 42 cells in
// week-major order, row 0 columns 0..6 first, each with the day number or 0
// for a blank cell, last set on the final cell. A year outside 1800..3000 or,
// with a good year, a month outside 1..12 gives one error item with last set.
// The first cell of an item passes the three front-end stages, the queue, the
// cell walk and the output register before it shows on o_cell.
// Throughput: one cell per cycle from the cell counter in the back end while
// o_cell is not stalled; a valid pair gives 42 cells and an error item one, and
// the next item's first cell follows straight on when the queue holds it.
// The front end is a three-stage pipeline feeding a four-entry queue, so up
// to seven items may be accepted ahead of the one being emitted.
// A stall on o_cell holds the cell in the output register; the cell walk and
// then the queue fill up, and i_req.ready drops once the queue is full and the last front-end stage holds an item.
// Reset (i_rst_n low, synchronous) empties the pipeline and the queue, stops the
// cell walk and drops o_cell.valid; nothing else needs clearing.
module month_calendar_grid_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcg_in_if.sink      i_req,
    mcg_out_if.source   o_cell
);

    logic                   q_full;
    logic                   q_nonempty;
    logic                   push;
    logic                   pop;
    mcg_pkg::t_grid_desc    push_desc;
    mcg_pkg::t_grid_desc    head_desc;

    // classify and find month length and first weekday
    mcg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_desc (push_desc)
    );

    // descriptor queue
    mcg_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_desc (push_desc),
        .i_pop       (pop),
        .o_head      (head_desc),
        .o_full      (q_full),
        .o_nonempty  (q_nonempty)
    );

    // cell generator and output register
    mcg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_desc),
        .i_nonempty (q_nonempty),
        .o_pop      (pop),
        .o_cell     (o_cell)
    );

endmodule

@@ bench/tb_month_calendar_grid_top.sv @@
module tb_month_calendar_grid_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_STALL     = 300;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct {
        logic [3:0]  month;
        logic [11:0] year;
    } t_month_req;

    typedef struct {
        logic [2:0]       week_row;
        logic [2:0]       weekday_col;
        logic [4:0]       day_number;
        mcg_pkg::t_status status;
        logic             last;
    } t_grid_cell;

    logic i_clk;
    logic i_rst_n;

    mcg_in_if  req_if ();
    mcg_out_if cell_if ();

    month_calendar_grid_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_cell  (cell_if)
    );

    t_month_req pending_reqs[$];
    t_grid_cell expected_cells[$];
    int         mismatch_count = 0;
    int         send_idle_pct  = 38;
    int         recv_idle_pct  = 74;
    bit         long_stall_armed = 1'b0;
    bit         long_stall_taken = 1'b0;
    int         stall_left       = 0;
    int         quiet_cycles     = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit is_leap(int y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int days_of_month(int m, int y);
        if (m == 2) begin
            return is_leap(y) ? 29 : 28;
        end else if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return 31;
    endfunction

    // weekday of the first of the month, 0 monday; serial day 1 is a monday
    function automatic int first_weekday(int m, int y);
        int serial;
        int prev_y;
        serial = 1 + (m * 3057 - 3007) / 100;
        prev_y = y - 1;
        if (m > 2) begin
            serial -= is_leap(y) ? 1 : 2;
        end
        serial += prev_y * 365 + prev_y / 4 - prev_y / 100 + prev_y / 400;
        return (serial - 1) % 7;
    endfunction

    // grid cells (or the error item) caused by one request
    function automatic void predict_grid(t_month_req r);
        t_grid_cell c;
        int m;
        int y;
        int ndays;
        int first;
        m = int'(r.month);
        y = int'(r.year);
        c.week_row    = 3'd0;
        c.weekday_col = 3'd0;
        c.day_number  = 5'd0;
        c.last        = 1'b1;
        if (y < mcg_pkg::YEAR_MIN || y > mcg_pkg::YEAR_MAX) begin
            c.status = mcg_pkg::ST_YEAR_RANGE;
            expected_cells.push_back(c);
            return;
        end
        if (m < 1 || m > mcg_pkg::MONTH_MAX) begin
            c.status = mcg_pkg::ST_MONTH_RANGE;
            expected_cells.push_back(c);
            return;
        end
        ndays = days_of_month(m, y);
        first = first_weekday(m, y);
        for (int k = 0; k < mcg_pkg::GRID_CELLS; k++) begin
            c.week_row    = 3'(k / mcg_pkg::GRID_COLS);
            c.weekday_col = 3'(k % mcg_pkg::GRID_COLS);
            c.day_number  = (k >= first && k - first < ndays) ? 5'(k - first + 1) : 5'd0;
            c.status      = mcg_pkg::ST_OK;
            c.last        = (k == mcg_pkg::GRID_CELLS - 1);
            expected_cells.push_back(c);
        end
    endfunction

    function automatic t_month_req random_request();
        t_month_req r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            r.month = 4'($urandom_range(1, 12));
            r.year  = 12'($urandom_range(mcg_pkg::YEAR_MIN, mcg_pkg::YEAR_MAX));
        end else if (pick < 88) begin
            // bad month with a good year: 13, 14, 15 or 0
            r.month = 4'($urandom_range(13, 16) % 16);
            r.year  = 12'($urandom_range(mcg_pkg::YEAR_MIN, mcg_pkg::YEAR_MAX));
        end else if (pick < 95) begin
            r.month = 4'($urandom_range(0, 15));
            r.year  = $urandom_range(0, 1) ?
                      12'($urandom_range(0, mcg_pkg::YEAR_MIN - 1)) :
                      12'($urandom_range(mcg_pkg::YEAR_MAX + 1, 4095));
        end else begin
            r.month = 4'($urandom);
            r.year  = 12'($urandom);
        end
        return r;
    endfunction

    task automatic queue_req(input int m, input int y);
        t_month_req r;
        r.month = 4'(m);
        r.year  = 12'(y);
        pending_reqs.push_back(r);
    endtask

    task automatic wait_for_sender();
        while (pending_reqs.size() != 0 || req_if.valid) @(posedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin : drive_req
        t_month_req nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.month <= 4'd0;
            req_if.year  <= 12'd0;
        end else if (!req_if.valid || req_if.ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pending_reqs.pop_front();
                req_if.valid <= 1'b1;
                req_if.month <= nxt.month;
                req_if.year  <= nxt.year;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off when armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cell_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            cell_if.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (long_stall_armed && !long_stall_taken) begin
            cell_if.ready    <= 1'b0;
            stall_left       <= LONG_STALL;
            long_stall_taken <= 1'b1;
        end else begin
            cell_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // predict on every accepted request
    always @(posedge i_clk) begin : watch_req
        t_month_req r;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            r.month = req_if.month;
            r.year  = req_if.year;
            predict_grid(r);
        end
    end

    // compare every accepted cell with the oldest prediction
    always @(posedge i_clk) begin : check_cell
        t_grid_cell want;
        if (i_rst_n && cell_if.valid && cell_if.ready) begin
            if (expected_cells.size() == 0) begin
                $error("unexpected cell: row %0d col %0d day %0d status %0d last %0d",
                       cell_if.week_row, cell_if.weekday_col, cell_if.day_number,
                       cell_if.status, cell_if.last);
                mismatch_count++;
            end else begin
                want = expected_cells.pop_front();
                if (cell_if.week_row !== want.week_row) begin
                    $error("week_row expected %0d actual %0d", want.week_row,
                           cell_if.week_row);
                    mismatch_count++;
                end
                if (cell_if.weekday_col !== want.weekday_col) begin
                    $error("weekday_col expected %0d actual %0d", want.weekday_col,
                           cell_if.weekday_col);
                    mismatch_count++;
                end
                if (cell_if.day_number !== want.day_number) begin
                    $error("day_number expected %0d actual %0d", want.day_number,
                           cell_if.day_number);
                    mismatch_count++;
                end
                if (cell_if.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, cell_if.status);
                    mismatch_count++;
                end
                if (cell_if.last !== want.last) begin
                    $error("last expected %0d actual %0d", want.last, cell_if.last);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (cell_if.valid && cell_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("month_calendar_grid_top regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // range edges and error precedence
        queue_req(1, 1800);
        queue_req(12, 3000);
        queue_req(1, 1799);
        queue_req(1, 3001);
        queue_req(5, 0);
        queue_req(15, 4095);
        queue_req(0, 2000);
        queue_req(13, 2000);
        queue_req(15, 1999);
        queue_req(0, 3001);
        // february across the leap rule
        queue_req(2, 2000);
        queue_req(2, 1900);
        queue_req(2, 2024);
        queue_req(2, 2021);
        // sunday first with 31 days fills the sixth row
        queue_req(8, 2021);
        for (int m = 3; m <= 11; m++) begin
            queue_req(m, 2023 + m);
        end
        for (int n = 0; n < 120; n++) begin
            pending_reqs.push_back(random_request());
        end
        wait_for_sender();

        send_idle_pct = 74;
        recv_idle_pct = 38;
        for (int n = 0; n < 120; n++) begin
            pending_reqs.push_back(random_request());
        end
        wait_for_sender();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < 110; n++) begin
            pending_reqs.push_back(random_request());
        end
        long_stall_armed = 1'b1;
        wait_for_sender();

        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("month_calendar_grid_top regression: pass");
        end else begin
            $display("month_calendar_grid_top regression: fail");
        end
        $finish;
    end

endmodule
